// ===== src/pct_pkg.sv =====
package pct_pkg;

  localparam int NODES_DEFAULT = 32;
  localparam int COORD_W = 20;
  localparam int TIME_W = 32;
  localparam int SUM_W = 40;
  localparam int RAD_W = 42;
  localparam int CNT_W = 6;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_END = 2'd1;
  localparam logic [1:0] EV_SUMMARY = 2'd2;

  localparam logic [0:0] REG_RADIUS = 1'd0;
  localparam logic [0:0] REG_COUNT = 1'd1;

endpackage

// ===== src/proximity_contact_tracker.sv =====
// proximity contact tracker
// input channel: in_valid / in_stall carries one position update
//   (node_id, pos_x, pos_y, node_on, time_now). output channel: out_valid /
//   out_stall carries one start or end event per changed pair in increasing
//   peer order, then a summary transfer with last set.
// configuration: apb port, radius_squared at 0x0, node_count at 0x8 (64-bit
//   data); write only while the block is idle.
// sequence: each other node in use passes through memory read, difference,
//   square, and compare and pair table update states; an event adds an emit
//   step, and the node itself is skipped in the read state. one update is in
//   work at a time and in_stall stays high until its summary is loaded; an
//   ignored update goes straight to its summary.
// reset: positions zero, all nodes powered, no links, contact totals zero.
//   a clearing pass then zeroes the contact total memory, all 2^(2*clog2(NODES))
//   pairs (1024 for 32 nodes), one pair per cycle while in_stall stays high.
// a stalled receiver holds the result register; the sequencer waits on it.
module proximity_contact_tracker
  import pct_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [$clog2(NODES)-1:0]  node_id,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic                      node_on,
  input  logic [TIME_W-1:0]         time_now,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [$clog2(NODES)-1:0]  peer_id,
  output logic [1:0]                event_kind,
  output logic [SUM_W-1:0]          contact_sum,
  output logic                      any_changed,
  output logic                      last
);

  localparam int IW = $clog2(NODES);
  localparam int PW = 2 * IW;
  localparam int PAIRS = 1 << PW;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_MUL, S_SQR, S_UPD, S_EMIT, S_SUM
  } state_t;

  state_t state;

  logic [RAD_W-1:0] radius_squared;
  logic [CNT_W-1:0] node_count;

  // node tables and pair tables
  logic [COORD_W-1:0] xmem [NODES];
  logic [COORD_W-1:0] ymem [NODES];
  logic [NODES-1:0]   pwr_off;
  logic [NODES-1:0]   link_bits [NODES];
  logic [TIME_W-1:0]  start_mem [PAIRS];
  logic [SUM_W-1:0]   total_mem [PAIRS];

  logic [IW-1:0]      cur_id;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic               cur_on;
  logic [TIME_W-1:0]  cur_time;
  logic [IW:0]        peer;
  logic [IW:0]        limit;
  logic [PW-1:0]      clr_addr;
  logic               changed;

  logic [COORD_W-1:0] rd_x, rd_y;
  logic [TIME_W-1:0]  rd_start;
  logic [SUM_W-1:0]   rd_total;
  logic               peer_on, was_linked;
  logic signed [COORD_W:0] dx, dy;
  logic [2*COORD_W+1:0] sq_x, sq_y;

  logic [IW-1:0] pk;
  logic [IW-1:0] hi, lo;
  logic [PW-1:0] pidx;
  logic [CNT_W:0] cnt_eff;
  logic [2*COORD_W+2:0] d2;
  logic now_linked;
  logic [TIME_W-1:0] dur;
  logic [SUM_W:0] tot_sum;
  logic [SUM_W-1:0] tot_sat;
  logic out_load;

  assign pk = peer[IW-1:0];
  assign hi = (pk > cur_id) ? pk : cur_id;
  assign lo = (pk > cur_id) ? cur_id : pk;
  assign pidx = {hi, lo};
  assign cnt_eff = ({1'b0, node_count} > (CNT_W+1)'(NODES)) ? (CNT_W+1)'(NODES)
                   : {1'b0, node_count};
  assign d2 = {1'b0, sq_x} + {1'b0, sq_y};
  assign now_linked = cur_on && peer_on && (d2 < {1'b0, radius_squared});
  // elapsed time wraps at the time width
  assign dur = cur_time - rd_start;
  assign tot_sum = {1'b0, rd_total} + {{(SUM_W+1-TIME_W){1'b0}}, dur};
  assign tot_sat = tot_sum[SUM_W] ? SUM_MAX : tot_sum[SUM_W-1:0];
  assign out_load = (state == S_EMIT || state == S_SUM) && (!out_valid || !out_stall);

  assign pready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= '0;
      node_count <= CNT_W'(32);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:3])
        REG_RADIUS: radius_squared <= pwdata[RAD_W-1:0];
        REG_COUNT: node_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:3])
      REG_RADIUS: prdata = 64'(radius_squared);
      REG_COUNT: prdata = 64'(node_count);
      default: prdata = '0;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      total_mem[clr_addr] <= '0;
      if (clr_addr < PW'(NODES)) begin
        xmem[clr_addr[IW-1:0]] <= '0;
        ymem[clr_addr[IW-1:0]] <= '0;
      end
    end
    if (state == S_IDLE && in_valid && (CNT_W+1)'(node_id) < cnt_eff) begin
      xmem[node_id] <= pos_x;
      ymem[node_id] <= pos_y;
    end
    if (state == S_READ) begin
      rd_x <= xmem[pk];
      rd_y <= ymem[pk];
      rd_start <= start_mem[pidx];
      rd_total <= total_mem[pidx];
    end
    if (state == S_UPD && !was_linked && now_linked)
      start_mem[pidx] <= cur_time;
    if (state == S_UPD && was_linked && !now_linked)
      total_mem[pidx] <= tot_sat;
  end

  always_ff @(posedge clk) begin
    dx <= {cur_x[COORD_W-1], cur_x} - {rd_x[COORD_W-1], rd_x};
    dy <= {cur_y[COORD_W-1], cur_y} - {rd_y[COORD_W-1], rd_y};
    sq_x <= $unsigned((2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx));
    sq_y <= $unsigned((2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      pwr_off <= '0;
      for (int i = 0; i < NODES; i++) link_bits[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PW'(PAIRS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_id <= node_id;
            cur_x <= pos_x;
            cur_y <= pos_y;
            cur_on <= node_on;
            cur_time <= time_now;
            changed <= 1'b0;
            peer <= '0;
            limit <= cnt_eff[IW:0];
            if ((CNT_W+1)'(node_id) < cnt_eff) begin
              pwr_off[node_id] <= !node_on;
              state <= S_READ;
            end else begin
              state <= S_SUM;
            end
          end
        end
        S_READ: begin
          if (peer >= limit) state <= S_SUM;
          else if (pk == cur_id) peer <= peer + 1'b1;
          else begin
            peer_on <= !pwr_off[pk];
            was_linked <= link_bits[hi][lo];
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_SQR;
        S_SQR: state <= S_UPD;
        S_UPD: begin
          if (was_linked != now_linked) begin
            link_bits[hi][lo] <= now_linked;
            state <= S_EMIT;
          end else begin
            peer <= peer + 1'b1;
            state <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            peer_id <= pk;
            event_kind <= was_linked ? EV_END : EV_START;
            contact_sum <= was_linked ? tot_sat : '0;
            any_changed <= 1'b0;
            last <= 1'b0;
            changed <= 1'b1;
            peer <= peer + 1'b1;
            state <= S_READ;
          end
        end
        S_SUM: begin
          if (out_load) begin
            out_valid <= 1'b1;
            peer_id <= '0;
            event_kind <= EV_SUMMARY;
            contact_sum <= '0;
            any_changed <= changed;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_sum_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == EV_SUMMARY) == last))
    else $error("summary and last disagree");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !in_stall)
    else $error("stall while idle");
  a_end_nonzero_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_START) |-> (contact_sum == '0))
    else $error("start event with sum");
  a_peer_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (peer < limit))
    else $error("peer beyond count");
`endif

endmodule

// ===== sim/proximity_contact_tracker_tb.sv =====
`timescale 1ns / 1ps

module proximity_contact_tracker_tb;
  import pct_pkg::*;

  localparam int NODES = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [3:0] ADDR_RADIUS = 4'(REG_RADIUS) << 3;
  localparam logic [3:0] ADDR_COUNT = 4'(REG_COUNT) << 3;

  typedef struct packed {
    logic [4:0]  node_id;
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic        node_on;
    logic [31:0] time_now;
  } update_t;

  typedef struct packed {
    logic [4:0]  peer_id;
    logic [1:0]  event_kind;
    logic [39:0] contact_sum;
    logic        any_changed;
    logic        last;
  } event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [4:0] node_id = '0;
  logic signed [19:0] pos_x = '0, pos_y = '0;
  logic node_on = 1'b0;
  logic [31:0] time_now = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [4:0] peer_id;
  logic [1:0] event_kind;
  logic [39:0] contact_sum;
  logic any_changed, last;

  proximity_contact_tracker #(.NODES(NODES)) i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tracker shadow state
  logic [41:0] radius_sq;
  logic [5:0]  nodes_used;
  logic signed [19:0] x_tab[NODES], y_tab[NODES];
  logic        power_tab[NODES];
  logic [31:0] link_tab[NODES];
  logic [31:0] start_tab[NODES*NODES];
  logic [39:0] total_tab[NODES*NODES];

  update_t pending_updates[$];
  event_t  expected_events[$];
  int errors = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;

  function automatic void queue_update(update_t u);
    pending_updates.insert(pending_updates.size(), u);
  endfunction

  function automatic void queue_event(event_t e);
    expected_events.insert(expected_events.size(), e);
  endfunction

  function automatic bit pair_linked(int a, int b);
    logic signed [63:0] dx, dy;
    logic [63:0] d2;
    dx = 64'(x_tab[a]) - 64'(x_tab[b]);
    dy = 64'(y_tab[a]) - 64'(y_tab[b]);
    d2 = dx * dx + dy * dy;
    return power_tab[a] && power_tab[b] && (d2 < {22'd0, radius_sq});
  endfunction

  task automatic track_update(update_t u);
    int cnt, hi, lo, idx;
    bit was, now_l, changed;
    logic [31:0] dur;
    logic [40:0] tot;
    event_t e;
    changed = 0;
    cnt = (nodes_used > NODES) ? NODES : nodes_used;
    if (u.node_id < cnt) begin
      x_tab[u.node_id] = u.pos_x;
      y_tab[u.node_id] = u.pos_y;
      power_tab[u.node_id] = u.node_on;
      for (int p = 0; p < cnt; p++) begin
        if (p == u.node_id) continue;
        hi = (p > u.node_id) ? p : u.node_id;
        lo = (p > u.node_id) ? u.node_id : p;
        idx = hi * NODES + lo;
        was = link_tab[hi][lo];
        now_l = pair_linked(hi, lo);
        if (!was && now_l) begin
          start_tab[idx] = u.time_now;
          link_tab[hi][lo] = 1'b1;
          e = '{peer_id: 5'(p), event_kind: EV_START, contact_sum: '0,
                any_changed: 1'b0, last: 1'b0};
          queue_event(e);
          changed = 1;
        end else if (was && !now_l) begin
          dur = u.time_now - start_tab[idx];
          tot = {1'b0, total_tab[idx]} + {9'd0, dur};
          if (tot[40]) tot = {1'b0, {40{1'b1}}};
          total_tab[idx] = tot[39:0];
          link_tab[hi][lo] = 1'b0;
          e = '{peer_id: 5'(p), event_kind: EV_END, contact_sum: tot[39:0],
                any_changed: 1'b0, last: 1'b0};
          queue_event(e);
          changed = 1;
        end
      end
    end
    e = '{peer_id: '0, event_kind: EV_SUMMARY, contact_sum: '0,
          any_changed: changed, last: 1'b1};
    queue_event(e);
  endtask

  // accept flags sampled at the rising edge
  logic in_stall_q = 1'b1;
  logic out_take_q = 1'b0;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    out_take_q <= out_valid && !out_stall;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        track_update(pending_updates.pop_front());
        send_gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (in_valid && in_stall_q) begin
        // payload holds while stalled
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_updates.size() > 0) begin
        in_valid <= 1'b1;
        {node_id, pos_x, pos_y, node_on, time_now} <= pending_updates[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  event_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        got = '{peer_id, event_kind, contact_sum, any_changed, last};
        if (expected_events.size() == 0) begin
          $error("unexpected transfer: peer_id %0d kind %0d", peer_id, event_kind);
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (got.peer_id !== want.peer_id) begin
            $error("peer_id: expected %0d actual %0d", want.peer_id, got.peer_id);
            errors++;
          end
          if (got.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d actual %0d", want.event_kind, got.event_kind);
            errors++;
          end
          if (got.contact_sum !== want.contact_sum) begin
            $error("contact_sum: expected %0d actual %0d", want.contact_sum,
                   got.contact_sum);
            errors++;
          end
          if (got.any_changed !== want.any_changed) begin
            $error("any_changed: expected %0d actual %0d", want.any_changed,
                   got.any_changed);
            errors++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b1;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_take_q) begin
      recv_gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) recv_gap = 0;
      out_stall <= (recv_gap > 0);
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= (recv_gap > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RADIUS) radius_sq = val[41:0];
    else nodes_used = val[5:0];
  endtask

  task automatic drain;
    while (pending_updates.size() > 0 || in_valid || expected_events.size() > 0)
      @(posedge clk);
    repeat (3 * NODES + 20) @(posedge clk);
  endtask

  function automatic update_t rand_update(int span, int cnt);
    update_t u;
    u.node_id = 5'($urandom_range(0, cnt - 1));
    u.pos_x = 20'($signed($urandom_range(0, 2 * span)) - span);
    u.pos_y = 20'($signed($urandom_range(0, 2 * span)) - span);
    u.node_on = ($urandom_range(0, 5) != 0);
    u.time_now = $urandom;
    return u;
  endfunction

  task automatic hold_receiver;
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    update_t u;
    int cnt;
    radius_sq = '0;
    nodes_used = 6'd32;
    for (int i = 0; i < NODES; i++) begin
      x_tab[i] = '0; y_tab[i] = '0; power_tab[i] = 1'b1; link_tab[i] = '0;
    end
    for (int i = 0; i < NODES * NODES; i++) begin
      total_tab[i] = '0; start_tab[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // radius zero: nothing links
    queue_update('{5'd3, 20'd0, 20'd0, 1'b1, 32'd5});
    drain();
    reg_write(ADDR_RADIUS, 64'd400);
    reg_write(ADDR_COUNT, 64'd4);
    // start and end, time wrap, node off, id beyond count
    queue_update('{5'd0, 20'd0, 20'd0, 1'b1, 32'hFFFF_FFF0});
    queue_update('{5'd1, 20'd5, 20'd5, 1'b1, 32'hFFFF_FFF8});
    queue_update('{5'd1, 20'd20, 20'd0, 1'b1, 32'd10});
    queue_update('{5'd1, 20'd19, 20'd0, 1'b1, 32'd20});
    queue_update('{5'd2, 20'd1, 20'd1, 1'b0, 32'd30});
    queue_update('{5'd1, 20'h7FFFF, 20'h80000, 1'b1, 32'd40});
    queue_update('{5'd7, 20'd0, 20'd0, 1'b1, 32'd50});
    queue_update('{5'd31, 20'h80000, 20'h7FFFF, 1'b1, 32'd60});
    drain();
    // huge radius, corners, saturation pressure on totals
    reg_write(ADDR_RADIUS, {22'd0, 42'h3FF_FFFF_FFFF});
    reg_write(ADDR_COUNT, 64'd2);
    for (int i = 0; i < 6; i++) begin
      queue_update('{5'd0, 20'h80000, 20'h80000, 1'b1, 32'd0});
      queue_update('{5'd1, 20'h7FFFF, 20'h7FFFF, 1'b0, 32'hFFFF_FFFF});
      queue_update('{5'd1, 20'h7FFFF, 20'h7FFFF, 1'b1, 32'd0});
    end
    drain();
    reg_write(ADDR_COUNT, 64'd63);
    reg_write(ADDR_RADIUS, 64'd1);
    queue_update('{5'd31, 20'd0, 20'd0, 1'b1, 32'd1});
    queue_update('{5'd30, 20'd0, 20'd0, 1'b1, 32'd2});
    drain();

    // long receiver hold-off while updates keep coming
    reg_write(ADDR_RADIUS, 64'd40000);
    reg_write(ADDR_COUNT, 64'd8);
    for (int i = 0; i < 20; i++) queue_update(rand_update(300, 8));
    hold_receiver();
    drain();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cnt = 1; reg_write(ADDR_COUNT, 64'd1); end
        1: begin cnt = 32; reg_write(ADDR_COUNT, 64'd32); end
        default: begin
          cnt = $urandom_range(2, 12);
          reg_write(ADDR_COUNT, 64'(cnt));
        end
      endcase
      reg_write(ADDR_RADIUS, 64'($urandom_range(1000, 200000)));
      for (int i = 0; i < 70; i++) begin
        u = rand_update(($urandom_range(0, 9) == 0) ? 524287 : 600, cnt);
        if ($urandom_range(0, 15) == 0) u.node_id = 5'($urandom);
        queue_update(u);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pct_pkg.sv
src/proximity_contact_tracker.sv
sim/proximity_contact_tracker_tb.sv
